### hw/rtl/bbc_pkg.sv
// Shared constants, types and helpers for the bracket balance checker.
// No dependencies; imported by bracket_balance_checker.
`timescale 1ns / 1ps

package bbc_pkg;

    // Width of the internal signed net counters (legal range 4..32)
    localparam int COUNT_WIDTH = 16;

    // Width of the result net fields
    localparam int NET_WIDTH = 16;

    // Width used to compare a counter against the result field range
    localparam int EXT_WIDTH = (COUNT_WIDTH > NET_WIDTH) ? COUNT_WIDTH : NET_WIDTH;

    // Counter saturation limits
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    // Result field limits
    localparam logic signed [NET_WIDTH-1:0] NET_MAX = {1'b0, {(NET_WIDTH-1){1'b1}}};
    localparam logic signed [NET_WIDTH-1:0] NET_MIN = {1'b1, {(NET_WIDTH-1){1'b0}}};

    // Character codes
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LSQUARE   = 8'h5B;
    localparam logic [7:0] CH_RSQUARE   = 8'h5D;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;

    // Lexical comment context
    typedef enum logic [2:0] {
        CM_NONE  = 3'b001,
        CM_LINE  = 3'b010,
        CM_BLOCK = 3'b100
    } comment_mode_t;

    // Result of one saturating counter step
    typedef struct packed {
        logic signed [COUNT_WIDTH-1:0] count;
        logic                          sat;
    } count_step_t;

    // Step a counter up or down by one, holding at the limits
    function automatic count_step_t count_step(
        input logic signed [COUNT_WIDTH-1:0] cnt,
        input logic                          up,
        input logic                          down
    );
        count_step_t res;
        res.count = cnt;
        res.sat   = 1'b0;
        if (up) begin
            if (cnt == CNT_MAX) begin
                res.sat = 1'b1;
            end else begin
                res.count = cnt + COUNT_WIDTH'(1);
            end
        end else if (down) begin
            if (cnt == CNT_MIN) begin
                res.sat = 1'b1;
            end else begin
                res.count = cnt - COUNT_WIDTH'(1);
            end
        end
        return res;
    endfunction

    // Clamp a counter into the signed range of a result field
    function automatic logic signed [NET_WIDTH-1:0] net_clamp(
        input logic signed [COUNT_WIDTH-1:0] cnt
    );
        logic signed [EXT_WIDTH-1:0] ext;
        logic signed [EXT_WIDTH-1:0] hi;
        logic signed [EXT_WIDTH-1:0] lo;
        ext = EXT_WIDTH'(cnt);
        hi  = EXT_WIDTH'(NET_MAX);
        lo  = EXT_WIDTH'(NET_MIN);
        if (ext > hi) begin
            return NET_MAX;
        end else if (ext < lo) begin
            return NET_MIN;
        end
        return signed'(ext[NET_WIDTH-1:0]);
    endfunction

endpackage

### hw/rtl/bracket_balance_checker.sv
// Bracket balance checker: scans C source one word (byte) per cycle.
// The result appears at m_valid in the cycle after the last byte is accepted.
// Throughput: one byte per cycle through short logic into the state registers;
// input stalls only while a finished result waits for m_ready.
// Reset: aresetn (synchronous, active low) clears context, counters, result valid.
// Depends on bbc_pkg.
`timescale 1ns / 1ps

module bracket_balance_checker
    import bbc_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_text_byte,
    input  logic                        s_end_of_text,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_balanced,
    output logic signed [NET_WIDTH-1:0] m_brace_net,
    output logic signed [NET_WIDTH-1:0] m_square_net,
    output logic signed [NET_WIDTH-1:0] m_paren_net,
    output logic                        m_count_overflow
);

    // Context and counter state
    comment_mode_t                 mode_reg, mode_next;
    logic                          in_string_reg, in_string_next;
    logic                          in_char_reg, in_char_next;
    logic                          pend_slash_reg, pend_slash_next;
    logic                          pend_star_reg, pend_star_next;
    logic                          last_bs_reg, last_bs_next;
    logic signed [COUNT_WIDTH-1:0] brace_reg, brace_next;
    logic signed [COUNT_WIDTH-1:0] square_reg, square_next;
    logic signed [COUNT_WIDTH-1:0] paren_reg, paren_next;
    logic                          ovf_reg, ovf_next;

    // Result register
    logic                          m_valid_reg, m_valid_next;
    logic                          m_balanced_reg;
    logic signed [NET_WIDTH-1:0]   m_brace_reg;
    logic signed [NET_WIDTH-1:0]   m_square_reg;
    logic signed [NET_WIDTH-1:0]   m_paren_reg;
    logic                          m_ovf_reg;

    logic        s_accept;
    logic        opens_comment;
    logic        do_count;
    count_step_t brace_step;
    count_step_t square_step;
    count_step_t paren_step;

    // Take a word whenever the result slot is free or being drained
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // Comment opener seen outside a comment
    assign opens_comment = (mode_reg == CM_NONE) && pend_slash_reg &&
                           ((s_text_byte == CH_SLASH) || (s_text_byte == CH_STAR));

    // Count brackets only in plain code
    assign do_count = (mode_reg == CM_NONE) && !opens_comment &&
                      !in_string_reg && !in_char_reg;

    assign brace_step  = count_step(brace_reg,
                                    do_count && (s_text_byte == CH_LBRACE),
                                    do_count && (s_text_byte == CH_RBRACE));
    assign square_step = count_step(square_reg,
                                    do_count && (s_text_byte == CH_LSQUARE),
                                    do_count && (s_text_byte == CH_RSQUARE));
    assign paren_step  = count_step(paren_reg,
                                    do_count && (s_text_byte == CH_LPAREN),
                                    do_count && (s_text_byte == CH_RPAREN));

    // Advance lexical context for one byte
    always_comb begin
        mode_next       = mode_reg;
        in_string_next  = in_string_reg;
        in_char_next    = in_char_reg;
        pend_slash_next = pend_slash_reg;
        pend_star_next  = pend_star_reg;
        last_bs_next    = (s_text_byte == CH_BACKSLASH);
        brace_next      = brace_step.count;
        square_next     = square_step.count;
        paren_next      = paren_step.count;
        ovf_next        = ovf_reg || brace_step.sat || square_step.sat || paren_step.sat;
        case (mode_reg)
            CM_LINE: begin
                if (s_text_byte == CH_NEWLINE) begin
                    mode_next = CM_NONE;
                end
            end
            CM_BLOCK: begin
                if (pend_star_reg && (s_text_byte == CH_SLASH)) begin
                    mode_next      = CM_NONE;
                    pend_star_next = 1'b0;
                end else begin
                    pend_star_next = (s_text_byte == CH_STAR);
                end
            end
            default: begin
                if (opens_comment) begin
                    pend_slash_next = 1'b0;
                    pend_star_next  = 1'b0;
                    mode_next = (s_text_byte == CH_SLASH) ? CM_LINE : CM_BLOCK;
                end else begin
                    pend_slash_next = (s_text_byte == CH_SLASH);
                    if ((s_text_byte == CH_DQUOTE) && !in_char_reg) begin
                        if (!last_bs_reg) begin
                            in_string_next = !in_string_reg;
                        end
                    end else if ((s_text_byte == CH_SQUOTE) && !in_string_reg) begin
                        if (!last_bs_reg) begin
                            in_char_next = !in_char_reg;
                        end
                    end
                end
            end
        endcase
    end

    // Hold a result until taken, load one on the last byte
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (s_accept && s_end_of_text) begin
            m_valid_next = 1'b1;
        end
    end

    // Context and counters: update per word, clear after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (s_accept && s_end_of_text)) begin
            mode_reg       <= CM_NONE;
            in_string_reg  <= 1'b0;
            in_char_reg    <= 1'b0;
            pend_slash_reg <= 1'b0;
            pend_star_reg  <= 1'b0;
            last_bs_reg    <= 1'b0;
            brace_reg      <= '0;
            square_reg     <= '0;
            paren_reg      <= '0;
            ovf_reg        <= 1'b0;
        end else if (s_accept) begin
            mode_reg       <= mode_next;
            in_string_reg  <= in_string_next;
            in_char_reg    <= in_char_next;
            pend_slash_reg <= pend_slash_next;
            pend_star_reg  <= pend_star_next;
            last_bs_reg    <= last_bs_next;
            brace_reg      <= brace_next;
            square_reg     <= square_next;
            paren_reg      <= paren_next;
            ovf_reg        <= ovf_next;
        end
    end

    // Result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (s_accept && s_end_of_text) begin
            m_balanced_reg <= (brace_next == '0) && (square_next == '0) &&
                              (paren_next == '0);
            m_brace_reg    <= net_clamp(brace_next);
            m_square_reg   <= net_clamp(square_next);
            m_paren_reg    <= net_clamp(paren_next);
            m_ovf_reg      <= ovf_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_balanced       = m_balanced_reg;
    assign m_brace_net      = m_brace_reg;
    assign m_square_net     = m_square_reg;
    assign m_paren_net      = m_paren_reg;
    assign m_count_overflow = m_ovf_reg;

    // A pending slash only exists in plain code
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_slash_reg |-> (mode_reg == CM_NONE))
        else $error("pending slash outside plain code");

    // A pending star only exists inside a block comment
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_star_reg |-> (mode_reg == CM_BLOCK))
        else $error("pending star outside block comment");

    // The last byte produces a result and clears the counters
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_end_of_text) |=>
            (m_valid_reg && (brace_reg == '0) && (square_reg == '0) &&
             (paren_reg == '0) && !ovf_reg && (mode_reg == CM_NONE)))
        else $error("last byte did not yield a result or clear state");

    // A balanced result carries zero net counts
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_balanced_reg) |->
            ((m_brace_reg == '0) && (m_square_reg == '0) && (m_paren_reg == '0)))
        else $error("balanced result with nonzero net count");

endmodule
